// ----- rtl/psg_event_register_writer_macros.svh -----
// Assertion macros shared by the event register writer modules.
// No dependencies; include by bare file name inside a module body.
`ifndef PSG_EVENT_REGISTER_WRITER_MACROS_SVH
`define PSG_EVENT_REGISTER_WRITER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define PSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/psgewr_pkg.sv -----
// Shared types, codes and byte builders for the event register writer.
// No dependencies.
`timescale 1ns / 1ps

package psgewr_pkg;

  // Event kinds
  typedef enum logic [2:0] {
    CMD_DIRECT = 3'd0,
    CMD_PAN    = 3'd1,
    CMD_VOLUME = 3'd2,
    CMD_NOTE   = 3'd3,
    CMD_OFF    = 3'd4,
    CMD_NOISE  = 3'd5
  } cmd_t;

  localparam logic [7:0] PORT_LEFT   = 8'h50;
  localparam logic [7:0] PORT_RIGHT  = 8'h30;
  localparam logic [7:0] ATTEN_BASE  = 8'h9F;
  localparam logic [7:0] NOISE_BASE  = 8'hE3;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam logic [7:0] TONE_LATCH  = 8'h80;
  localparam logic [7:0] NOISE_LATCH = 8'hC0;

  localparam int MAX_BYTES = 8;

  typedef logic [3:0][7:0] quad_t;

  // One event's byte list, element 0 goes out first
  typedef struct packed {
    logic [3:0]                 count;
    logic [MAX_BYTES-1:0][7:0]  bytes;
  } job_t;

  // Clamp a 17-bit two's-complement level at zero and fold into an attenuation byte
  function automatic logic [7:0] atten_byte(input logic [16:0] lvl, input logic [1:0] c);
    logic [7:0] cl;
    cl = lvl[16] ? 8'h00 : lvl[7:0];
    return (ATTEN_BASE ^ cl) | {1'b0, c, 5'b0};
  endfunction

  // Four bytes: left port, left level, right port, right level
  function automatic quad_t vol_bytes(input logic [15:0] vol, input logic [15:0] pan,
                                      input logic [1:0] c);
    logic [16:0] left_lvl;
    logic [16:0] right_lvl;
    logic [16:0] pan_pos;
    logic [16:0] pan_neg;
    pan_pos   = pan[15] ? 17'd0 : {1'b0, pan};
    pan_neg   = pan[15] ? {1'b1, pan} : 17'd0;
    left_lvl  = {vol[15], vol} - pan_pos;
    right_lvl = {vol[15], vol} + pan_neg;
    return {atten_byte(right_lvl, c), PORT_RIGHT, atten_byte(left_lvl, c), PORT_LEFT};
  endfunction

endpackage

// ----- rtl/psgewr_front.sv -----
// Front end: accepts events, keeps voice state, builds each event's byte list.
// Depends on psgewr_pkg.
`timescale 1ns / 1ps

module psgewr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ev_valid,
  input  logic [2:0]         ev_cmd,
  input  logic               ev_noise,
  input  logic [1:0]         ev_voice,
  input  logic [15:0]        ev_value,
  output logic               ev_ready,
  output logic               push,
  output psgewr_pkg::job_t   push_job,
  input  logic               q_full
);
  import psgewr_pkg::*;

  logic [3:0][15:0] loud_r, loud_nxt;
  logic [3:0][15:0] pan_r, pan_nxt;
  logic [3:0][15:0] tone_r, tone_nxt;
  logic [3:0]       snd_r, snd_nxt;
  logic [15:0]      noise_r, noise_nxt;

  logic        accept;
  logic [1:0]  c;
  logic [7:0]  port;
  logic [15:0] vol_e;
  logic [15:0] pan_e;
  logic        tone_chg;
  job_t        job;

  assign ev_ready = !q_full;
  assign accept   = ev_valid && ev_ready;

  // Classify the event and build its bytes and the next voice state
  always_comb begin
    c         = ev_noise ? 2'd3 : ev_voice;
    port      = ev_noise ? PORT_RIGHT : PORT_LEFT;
    loud_nxt  = loud_r;
    pan_nxt   = pan_r;
    tone_nxt  = tone_r;
    snd_nxt   = snd_r;
    noise_nxt = noise_r;
    vol_e     = loud_r[c];
    pan_e     = pan_r[c];
    tone_chg  = tone_r[c] != ev_value;
    job       = '0;
    case (cmd_t'(ev_cmd))
      CMD_DIRECT: begin
        job.bytes[0] = port;
        job.bytes[1] = ev_value[7:0];
        job.count    = 4'd2;
      end
      CMD_PAN: begin
        pan_nxt[c] = ev_value;
        pan_e      = ev_value;
        if (snd_r[c]) begin
          job.bytes[3:0] = vol_bytes(vol_e, pan_e, c);
          job.count      = 4'd4;
        end
      end
      CMD_VOLUME: begin
        loud_nxt[c] = ev_value;
        vol_e       = ev_value;
        if (snd_r[c]) begin
          job.bytes[3:0] = vol_bytes(vol_e, pan_e, c);
          job.count      = 4'd4;
        end
      end
      CMD_NOTE: begin
        if (tone_chg) begin
          tone_nxt[c]    = ev_value;
          job.bytes[0]   = port;
          job.bytes[1]   = (ev_value[7:0] & LOW_NIBBLE) | TONE_LATCH |
                           (ev_noise ? NOISE_LATCH : {1'b0, c, 5'b0});
          job.bytes[2]   = port;
          job.bytes[3]   = ev_value[11:4];
          job.count      = 4'd4;
        end
        if (!snd_r[c]) begin
          snd_nxt[c] = 1'b1;
          if (tone_chg) begin
            job.bytes[7:4] = vol_bytes(vol_e, pan_e, c);
            job.count      = 4'd8;
          end else begin
            job.bytes[3:0] = vol_bytes(vol_e, pan_e, c);
            job.count      = 4'd4;
          end
        end
      end
      CMD_OFF: begin
        if (snd_r[c]) begin
          snd_nxt[c]   = 1'b0;
          job.bytes[0] = PORT_LEFT;
          job.bytes[1] = ATTEN_BASE | {1'b0, c, 5'b0};
          job.bytes[2] = PORT_RIGHT;
          job.bytes[3] = ATTEN_BASE | {1'b0, c, 5'b0};
          job.count    = 4'd4;
        end
      end
      CMD_NOISE: begin
        if (ev_noise && (noise_r != ev_value)) begin
          noise_nxt    = ev_value;
          job.bytes[0] = PORT_RIGHT;
          job.bytes[1] = NOISE_BASE | {ev_value[5:0], 2'b00};
          job.count    = 4'd2;
        end
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // Drop events that emit nothing
  assign push     = accept && (job.count != 4'd0);
  assign push_job = job;

  // Commit voice state on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loud_r  <= {4{16'hFFFF}};
      pan_r   <= '0;
      tone_r  <= '0;
      snd_r   <= '0;
      noise_r <= 16'hFFFF;
    end else if (accept) begin
      loud_r  <= loud_nxt;
      pan_r   <= pan_nxt;
      tone_r  <= tone_nxt;
      snd_r   <= snd_nxt;
      noise_r <= noise_nxt;
    end
  end

endmodule

// ----- rtl/psgewr_queue.sv -----
// Two-entry job queue between the front end and the byte serializer.
// Depends on psgewr_pkg and the assertion macro header.
`timescale 1ns / 1ps

module psgewr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psgewr_pkg::job_t   push_job,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output psgewr_pkg::job_t   q_job
);
  import psgewr_pkg::*;

  job_t        slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_job   = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  `include "psg_event_register_writer_macros.svh"

  `PSG_ASSERT_NOW(a_q_no_overflow, push, !full || pop, "queue: push while full")
  `PSG_ASSERT_NOW(a_q_no_underflow, pop, q_valid, "queue: pop while empty")
  `PSG_ASSERT_NEXT(a_q_fill, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "queue: count lost a push")

endmodule

// ----- rtl/psgewr_back.sv -----
// Back end: serializes queued jobs into output words through a register stage.
// Depends on psgewr_pkg and the assertion macro header.
`timescale 1ns / 1ps

module psgewr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  psgewr_pkg::job_t   q_job,
  output logic               pop,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_last,
  input  logic               out_ready
);
  import psgewr_pkg::*;

  job_t        job_r;
  logic        busy_r, busy_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        oval_r, oval_nxt;
  logic [7:0]  obyte_r;
  logic        olast_r;

  logic        adv;
  logic        at_last;
  logic        load;

  assign adv     = busy_r && (!oval_r || out_ready);
  assign at_last = {1'b0, idx_r} == (job_r.count - 4'd1);
  assign load    = q_valid && (!busy_r || (adv && at_last));
  assign pop     = load;

  // Step through the current job, pick up a new one when idle or after its last word
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (adv) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + 3'd1;
    end
    if (adv) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      oval_r <= oval_nxt;
    end
  end

  // Hold payload: job buffer and output word
  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
    if (adv) begin
      obyte_r <= job_r.bytes[idx_r];
      olast_r <= at_last;
    end
  end

  assign out_valid = oval_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

  `include "psg_event_register_writer_macros.svh"

  `PSG_ASSERT_NOW(a_b_job_size, load, (q_job.count != 4'd0) && (q_job.count <= 4'd8), "back: bad job size")
  `PSG_ASSERT_NEXT(a_b_last_flag, adv && at_last, out_valid && out_last, "back: final word not flagged")
  `PSG_ASSERT_NEXT(a_b_idx_hold, busy_r && !adv && !load, $stable(idx_r), "back: index moved while stalled")

endmodule

// ----- rtl/psg_event_register_writer.sv -----
// Top level of the event register writer: front end, job queue, serializer.
// Depends on psgewr_pkg, psgewr_front, psgewr_queue, psgewr_back.
//
//  channel | direction | tdata fields (low bit up)          | tuser / tlast
//  in_     | slave     | voice[1:0], value[17:2], pad to 24  | tuser: command[2:0], on_noise_chip[3]
//  out_    | master    | out_byte[7:0]                       | tlast: last
//
// An event is accepted while the two-entry job queue has room, so events
// may arrive back to back; its state update is registered on acceptance.
// The serializer sends one word per cycle while out_tready is high: an event
// yields 0, 2, 4 or 8 output words, and the output port is what sets the sustained rate.
// Synchronous reset restores all voice state; there is no clearing pass.
// An output stall holds the word in place; the queue holds up to two more jobs.
`timescale 1ns / 1ps

module psg_event_register_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // voice[1:0], value[17:2], zero[23:18]
  input  logic [3:0]  in_tuser,   // command[2:0], on_noise_chip[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast
);
  import psgewr_pkg::*;

  logic  push;
  job_t  push_job;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  job_t  q_job;

  psgewr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (in_tvalid),
    .ev_cmd   (in_tuser[2:0]),
    .ev_noise (in_tuser[3]),
    .ev_voice (in_tdata[1:0]),
    .ev_value (in_tdata[17:2]),
    .ev_ready (in_tready),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  psgewr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  psgewr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule
